// ----- src/psc_pkg.sv -----
package psc_pkg;

  // Configuration port
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_SENS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TCS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TCO    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TREF   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TSENS  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PTRIM  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_TTRIM  = 3'd7;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Running average
  localparam int AVG_W = 32;
  localparam int CNT_W = 4;
  localparam int NUM_W = 37;
  localparam int DEN_W = CNT_W + 1;

  // Result fields
  localparam int T_W = 18;
  localparam int P_W = 21;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/pressure_sensor_compensation.sv -----
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tdata: raw_pressure, raw_temperature; s_tuser: bus_ok
// m        out  m_tvalid/m_tready  m_tdata: temp_centideg, pressure_avg_decimbar
// cfg      in   cfg_we             cfg_addr register index, cfg_wdata value
//
// A sample is accepted only in idle; it runs through the sequencer steps and waits
// on the one-bit-per-cycle average divider before the output word is loaded, so
// the next sample cannot start before the current one has loaded its output word.
// A sample with bus_ok low is dropped and gives no word.
// Reset (rst, synchronous) clears state, configuration, m_tvalid, the average and its count.
// The result waits in the output register; a stalled output holds the block at
// its final step while the next sample may not start before it.
module pressure_sensor_compensation import psc_pkg::*; #(
  parameter int AVG_LIMIT     = 10,
  parameter int AVG_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic                  s_tuser,   // [0] bus_ok
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // [17:0] temp_centideg, [38:18] pressure_avg_decimbar
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam logic signed [AVG_W:0] HALF = (AVG_W+1)'((1 << AVG_FRAC_BITS) >> 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DT, ST_MT, ST_MOFF, ST_MSENS, ST_MDT2, ST_MDEV, ST_CORR,
    ST_MPH, ST_MPL, ST_ACC, ST_Y, ST_PX, ST_MN, ST_NUM, ST_DIV, ST_FIN
  } state_t;

  state_t state;

  // Configuration
  logic [15:0]        c_sens, c_off, c_tcs, c_tco, c_tref, c_tsens;
  logic signed [11:0] trim_p;
  logic signed [10:0] trim_t;

  // Working registers
  logic [23:0]               d1, d2;
  logic signed [24:0]        dt;
  logic signed [19:0]        t;
  logic signed [39:0]        off, sens;
  logic [48:0]               dt2;
  logic signed [63:0]        acc;
  logic signed [44:0]        y;
  logic signed [P_W-1:0]     p;
  logic signed [T_W-1:0]     tout;
  logic signed [AVG_W-1:0]   avg;
  logic [CNT_W-1:0]          cnt;

  // Shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic                      div_start;
  logic signed [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]          div_den;
  div_stat_t                 div_stat;
  logic signed [NUM_W-1:0]   div_quo;

  psc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  psc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .stat(div_stat), .quo(div_quo)
  );

  logic signed [18:0] dev;
  assign dev = 19'(t - 20'sd2000);

  // Multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MT:    begin mul_a = {dt[24], dt}; mul_b = {16'b0, c_tsens}; end
      ST_MOFF:  begin mul_a = {dt[24], dt}; mul_b = {16'b0, c_tco}; end
      ST_MSENS: begin mul_a = {dt[24], dt}; mul_b = {16'b0, c_tcs}; end
      ST_MDT2:  begin mul_a = {dt[24], dt}; mul_b = {{7{dt[24]}}, dt}; end
      ST_MDEV:  begin mul_a = {{7{dev[18]}}, dev}; mul_b = {{13{dev[18]}}, dev}; end
      ST_MPH:   begin mul_a = {2'b0, d1}; mul_b = {{12{sens[39]}}, sens[39:20]}; end
      ST_MPL:   begin mul_a = {2'b0, d1}; mul_b = {12'b0, sens[19:0]}; end
      ST_MN:    begin mul_a = {{(MUL_A_W-CNT_W){1'b0}}, cnt}; mul_b = avg; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Truncating divisions by powers of two
  logic signed [MUL_P_W-1:0] q23, q7, q8;
  logic signed [63:0]        q21;
  logic signed [44:0]        q13;
  always_comb begin
    q23 = (prod + (prod[MUL_P_W-1] ? MUL_P_W'(8388607) : MUL_P_W'(0))) >>> 23;
    q7  = (prod + (prod[MUL_P_W-1] ? MUL_P_W'(127) : MUL_P_W'(0))) >>> 7;
    q8  = (prod + (prod[MUL_P_W-1] ? MUL_P_W'(255) : MUL_P_W'(0))) >>> 8;
    q21 = (acc + (acc[63] ? 64'(2097151) : 64'(0))) >>> 21;
    q13 = (y + (y[44] ? 45'(8191) : 45'(0))) >>> 13;
  end

  // Second-order correction terms
  logic        cold;
  logic [51:0] dt2x3, dt2x7;
  logic [19:0] t2c;
  logic [35:0] dd;
  logic [37:0] ddx3, ddx5;
  logic [39:0] off2, sens2;
  always_comb begin
    cold  = t < 20'sd2000;
    dt2x3 = {2'b0, dt2, 1'b0} + {3'b0, dt2};
    dt2x7 = {1'b0, dt2, 2'b0} + {2'b0, dt2, 1'b0} + {3'b0, dt2};
    t2c   = cold ? 20'(dt2x3 >> 33) : 20'(dt2x7 >> 37);
    dd    = prod[35:0];
    ddx3  = {1'b0, dd, 1'b0} + {2'b0, dd};
    ddx5  = {dd, 2'b0} + {2'b0, dd};
    off2  = cold ? 40'(ddx3 >> 1) : 40'(dd >> 4);
    sens2 = cold ? 40'(ddx5 >> 3) : '0;
  end

  // Trim and saturation
  logic signed [33:0]  psum;
  logic signed [20:0]  tsum;
  logic signed [P_W-1:0] p_sat;
  logic signed [T_W-1:0] t_sat;
  logic signed [AVG_W:0] r_avg;
  logic signed [P_W-1:0] p_out;
  always_comb begin
    psum = q13[33:0] + {{22{trim_p[11]}}, trim_p};
    tsum = {t[19], t} + {{10{trim_t[10]}}, trim_t};
    if (psum < -34'sd1048576)      p_sat = -21'sd1048576;
    else if (psum > 34'sd1048575)  p_sat = 21'sd1048575;
    else                           p_sat = psum[P_W-1:0];
    if (tsum < -21'sd131072)       t_sat = -18'sd131072;
    else if (tsum > 21'sd131071)   t_sat = 18'sd131071;
    else                           t_sat = tsum[T_W-1:0];
    r_avg = ($signed({avg[AVG_W-1], avg}) + HALF) >>> AVG_FRAC_BITS;
    if (r_avg < -33'sd1048576)     p_out = -21'sd1048576;
    else if (r_avg > 33'sd1048575) p_out = 21'sd1048575;
    else                           p_out = r_avg[P_W-1:0];
  end

  // Average numerator and divisor
  always_comb begin
    div_start = state == ST_NUM;
    div_num   = prod[NUM_W-1:0] + ({{(NUM_W-P_W){p[P_W-1]}}, p} <<< AVG_FRAC_BITS);
    div_den   = {1'b0, cnt} + 1'b1;
  end

  assign s_tready = state == ST_IDLE;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      c_sens <= '0; c_off <= '0; c_tcs <= '0; c_tco <= '0;
      c_tref <= '0; c_tsens <= '0; trim_p <= '0; trim_t <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SENS:  c_sens  <= cfg_wdata;
        REG_OFF:   c_off   <= cfg_wdata;
        REG_TCS:   c_tcs   <= cfg_wdata;
        REG_TCO:   c_tco   <= cfg_wdata;
        REG_TREF:  c_tref  <= cfg_wdata;
        REG_TSENS: c_tsens <= cfg_wdata;
        REG_PTRIM: trim_p  <= cfg_wdata[11:0];
        REG_TTRIM: trim_t  <= cfg_wdata[10:0];
        default:   ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      avg      <= '0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tuser) begin
            d1    <= s_tdata[23:0];
            d2    <= s_tdata[47:24];
            state <= ST_DT;
          end
        end
        ST_DT: begin
          dt    <= $signed({1'b0, d2}) - $signed({1'b0, c_tref, 8'b0});
          state <= ST_MT;
        end
        ST_MT:    state <= ST_MOFF;
        ST_MOFF: begin
          t     <= 20'(q23 + MUL_P_W'(2000));
          state <= ST_MSENS;
        end
        ST_MSENS: begin
          off   <= 40'($signed({26'b0, c_off, 16'b0}) + q7);
          state <= ST_MDT2;
        end
        ST_MDT2: begin
          sens  <= 40'($signed({27'b0, c_sens, 15'b0}) + q8);
          state <= ST_MDEV;
        end
        ST_MDEV: begin
          dt2   <= prod[48:0];
          state <= ST_CORR;
        end
        ST_CORR: begin
          t     <= t - $signed(t2c);
          off   <= off - $signed(off2);
          sens  <= sens - $signed(sens2);
          state <= ST_MPH;
        end
        ST_MPH:   state <= ST_MPL;
        ST_MPL: begin
          acc   <= {prod[43:0], 20'b0};
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc   <= acc + {{(64-MUL_P_W){prod[MUL_P_W-1]}}, prod};
          state <= ST_Y;
        end
        ST_Y: begin
          y     <= q21[44:0] - {{5{off[39]}}, off};
          state <= ST_PX;
        end
        ST_PX: begin
          p     <= p_sat;
          tout  <= t_sat;
          state <= ST_MN;
        end
        ST_MN:    state <= ST_NUM;
        ST_NUM:   state <= ST_DIV;
        ST_DIV: begin
          if (div_stat.done) begin
            avg <= div_quo[AVG_W-1:0];
            if (cnt < CNT_W'(AVG_LIMIT)) cnt <= cnt + 1'b1;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Load output once the register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, p_out, tout};
            state    <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(AVG_LIMIT))
    else $error("average count above limit");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside its wait step");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> state == ST_IDLE)
    else $error("bus fault word started a computation");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FIN))
    else $error("output word raised outside final step");
`endif

endmodule

// ----- src/psc_mul.sv -----
module psc_mul import psc_pkg::*; (
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [MUL_P_W-1:0]  prod
);

  // Register every product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- src/psc_div.sv -----
module psc_div import psc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic        [DEN_W-1:0]  den,
  output div_stat_t                stat,
  output logic signed [NUM_W-1:0]  quo
);

  localparam int CW = $clog2(NUM_W);

  logic             neg;
  logic [NUM_W-1:0] mag;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_nx;

  // One restoring step per cycle on the magnitude
  always_comb begin
    rem_sh = {rem, mag[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den};
    rem_nx = ge ? rem_sh - {1'b0, den} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        neg       <= num[NUM_W-1];
        mag       <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem       <= '0;
        cnt       <= '0;
      end else if (stat.busy) begin
        rem <= rem_nx[DEN_W-1:0];
        mag <= {mag[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Quotient truncates toward zero
  assign quo = neg ? -$signed(mag) : $signed(mag);

endmodule
